[rtl/twhp_pkg.sv]
// Shared widths, codes and transaction structs of the task watchdog health policy.
`default_nettype none

package twhp_pkg;

  localparam int CMD_W      = 2;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 8;
  localparam int FIG_W      = 32;
  localparam int KIB_W      = 16;
  localparam int KIB_SHIFT  = 10;
  localparam int STRIKE_W   = 8;
  localparam int STATUS_W   = 2;
  localparam int MEM_W      = 2;
  localparam int OUT_SLOT_W = 3;
  localparam int AGE_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WATCH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNWATCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KICK    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  localparam logic [MEM_W-1:0] MEM_NORMAL = 2'd0;
  localparam logic [MEM_W-1:0] MEM_WARN   = 2'd1;
  localparam logic [MEM_W-1:0] MEM_ALARM  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_ALARM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALARM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_WARN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WARN     = 3'd4;

  localparam logic [STRIKE_W-1:0] STRIKE_MAX = 8'hFF;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] time_ms;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] silence_limit_ms;
  } slot_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  task_stalled;
    logic [OUT_SLOT_W-1:0] stalled_slot;
    logic [AGE_W-1:0]      stalled_age_ms;
  } slot_rsp_t;

  typedef struct packed {
    logic [STRIKE_W-1:0] count;
    logic                restart;
    logic                halted;
  } strike_rsp_t;

endpackage

`default_nettype wire

[rtl/twhp_heap_grade.sv]
// Heap verdict: grades the free-memory figures against the alarm and warning floors.
`default_nettype none

module twhp_heap_grade (
  input  logic [twhp_pkg::FIG_W-1:0] internal_free_bytes,
  input  logic [twhp_pkg::FIG_W-1:0] largest_free_block,
  input  logic [twhp_pkg::FIG_W-1:0] total_free_bytes,
  input  logic [twhp_pkg::KIB_W-1:0] internal_alarm_kib,
  input  logic [twhp_pkg::KIB_W-1:0] block_alarm_kib,
  input  logic [twhp_pkg::KIB_W-1:0] internal_warn_kib,
  input  logic [twhp_pkg::KIB_W-1:0] total_warn_kib,
  output logic [twhp_pkg::MEM_W-1:0] memory_state
);
  import twhp_pkg::*;

  localparam int PAD_W = FIG_W - KIB_W - KIB_SHIFT;

  function automatic logic below_floor(input logic [FIG_W-1:0] figure,
                                       input logic [KIB_W-1:0] kib);
    logic [FIG_W-1:0] floor_bytes;
    floor_bytes = {{PAD_W{1'b0}}, kib, {KIB_SHIFT{1'b0}}};
    return (kib != '0) && (figure < floor_bytes);
  endfunction

  logic alarm;
  logic warn;

  assign alarm = below_floor(internal_free_bytes, internal_alarm_kib) ||
                 below_floor(largest_free_block, block_alarm_kib);
  assign warn  = below_floor(internal_free_bytes, internal_warn_kib) ||
                 below_floor(total_free_bytes, total_warn_kib);

  always_comb begin
    if (alarm) begin
      memory_state = MEM_ALARM;
    end else if (warn) begin
      memory_state = MEM_WARN;
    end else begin
      memory_state = MEM_NORMAL;
    end
  end

endmodule

`default_nettype wire

[rtl/twhp_strike.sv]
// Fatal strike counter with the halt latch that stops further ticks after a restart request.
`default_nettype none

module twhp_strike (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  logic                          fatal_condition,
  input  logic [twhp_pkg::STRIKE_W-1:0] strike_limit,
  output twhp_pkg::strike_rsp_t         rsp
);
  import twhp_pkg::*;

  logic [STRIKE_W-1:0] strikes_held;
  logic [STRIKE_W-1:0] strikes_next;
  logic [STRIKE_W-1:0] bumped;
  logic [STRIKE_W-1:0] lim;
  logic                halted;
  logic                halted_next;

  always_comb begin
    lim          = (strike_limit == '0) ? STRIKE_W'(1) : strike_limit;
    bumped       = (strikes_held == STRIKE_MAX) ? strikes_held : strikes_held + 1'b1;
    strikes_next = strikes_held;
    halted_next  = halted;
    rsp.halted   = halted;
    rsp.restart  = 1'b0;
    rsp.count    = '0;
    if (halted) begin
      rsp.count = strikes_held;
    end else if (!fatal_condition) begin
      strikes_next = '0;
    end else begin
      rsp.count    = bumped;
      strikes_next = bumped;
      if (bumped >= lim) begin
        halted_next = 1'b1;
        rsp.restart = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strikes_held <= '0;
      halted       <= 1'b0;
    end else if (commit) begin
      strikes_held <= strikes_next;
      halted       <= halted_next;
    end
  end

  a_restart_halts: assert property (@(posedge clk) disable iff (rst)
    commit && rsp.restart |=> halted)
    else $error("restart request did not halt the strike counter");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt latch cleared without reset");

  a_clean_tick_clears: assert property (@(posedge clk) disable iff (rst)
    commit && !halted && !fatal_condition |=> strikes_held == '0)
    else $error("tick without fatal condition left strikes counted");

endmodule

`default_nettype wire

[rtl/twhp_slot_engine.sv]
// Slot table memory and the sequencer that scans it one entry per cycle for every transaction.
`default_nettype none

module twhp_slot_engine #(
  parameter int WATCH_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                finish,
  input  twhp_pkg::slot_req_t req,
  output logic                busy,
  output logic                done,
  output twhp_pkg::slot_rsp_t rsp
);
  import twhp_pkg::*;

  localparam int SLOT_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(WATCH_SLOTS - 1);
  localparam int WORD_W = ID_W + 2 * TIME_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [WORD_W-1:0]      slot_mem [WATCH_SLOTS];
  logic [WORD_W-1:0]      rd_data;
  logic [SLOT_W-1:0]      rd_addr;
  logic [WATCH_SLOTS-1:0] occupied;

  logic [SLOT_W-1:0] cnt;
  logic              found;
  logic [SLOT_W-1:0] fnd_idx;
  logic [TIME_W-1:0] fnd_limit;
  logic              empty_found;
  logic [SLOT_W-1:0] empty_idx;
  logic              stall_seen;
  logic [SLOT_W-1:0] stall_idx;
  logic [TIME_W-1:0] worst;

  logic [ID_W-1:0]   rd_task;
  logic [TIME_W-1:0] rd_limit;
  logic [TIME_W-1:0] rd_kick;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] age;
  logic              occ;
  logic              over;
  logic              match;
  logic              empty_hit;

  logic                mem_we;
  logic                set_occ;
  logic                clr_occ;
  logic [SLOT_W-1:0]   wr_idx;
  logic [WORD_W-1:0]   wr_data;
  logic [STATUS_W-1:0] apply_status;

  assign rd_task  = rd_data[2*TIME_W +: ID_W];
  assign rd_limit = rd_data[TIME_W +: TIME_W];
  assign rd_kick  = rd_data[0 +: TIME_W];

  assign occ       = occupied[cnt];
  assign diff      = req.time_ms - rd_kick;
  assign age       = diff[TIME_W-1] ? '0 : diff;
  assign over      = (req.command == CMD_TICK) && occ && (age > rd_limit) && (age >= worst);
  assign match     = occ && !found && (rd_task == req.task_id);
  assign empty_hit = !occ && !empty_found;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  always_comb begin
    if (state == ST_SCAN && cnt != LAST) begin
      rd_addr = cnt + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    mem_we       = 1'b0;
    set_occ      = 1'b0;
    clr_occ      = 1'b0;
    wr_idx       = fnd_idx;
    wr_data      = {req.task_id, fnd_limit, req.time_ms};
    apply_status = STATUS_OK;
    case (req.command)
      CMD_WATCH: begin
        if (req.task_id == '0) begin
          apply_status = STATUS_INVALID;
        end else if (found || empty_found) begin
          mem_we  = 1'b1;
          set_occ = 1'b1;
          wr_idx  = found ? fnd_idx : empty_idx;
          wr_data = {req.task_id, req.silence_limit_ms, req.time_ms};
        end else begin
          apply_status = STATUS_NO_SLOT;
        end
      end
      CMD_UNWATCH: begin
        if (found && req.task_id != '0) begin
          clr_occ = 1'b1;
        end else begin
          apply_status = STATUS_NOT_FOUND;
        end
      end
      CMD_KICK: begin
        if (found && req.task_id != '0) begin
          mem_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state != ST_APPLY) begin
      mem_we  = 1'b0;
      set_occ = 1'b0;
      clr_occ = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (cnt == LAST) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_DONE;
      ST_DONE:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= slot_mem[rd_addr];
    if (mem_we) begin
      slot_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occupied <= '0;
    end else begin
      state <= state_next;
      if (set_occ) begin
        occupied[wr_idx] <= 1'b1;
      end
      if (clr_occ) begin
        occupied[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt         <= '0;
        found       <= 1'b0;
        empty_found <= 1'b0;
        stall_seen  <= 1'b0;
        worst       <= '0;
      end
      ST_SCAN: begin
        if (match) begin
          found     <= 1'b1;
          fnd_idx   <= cnt;
          fnd_limit <= rd_limit;
        end
        if (empty_hit) begin
          empty_found <= 1'b1;
          empty_idx   <= cnt;
        end
        if (over) begin
          stall_seen <= 1'b1;
          stall_idx  <= cnt;
          worst      <= age;
        end
        if (cnt != LAST) begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_APPLY: begin
        rsp.status         <= apply_status;
        rsp.task_stalled   <= stall_seen;
        rsp.stalled_slot   <= stall_seen ? OUT_SLOT_W'(stall_idx) : '0;
        rsp.stalled_age_ms <= stall_seen ? worst[AGE_W-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("transaction started while the slot scan was busy");

  a_stall_age_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY && stall_seen |-> worst != '0 && !worst[TIME_W-1])
    else $error("reported stall age out of range");

  a_watch_marks_slot: assert property (@(posedge clk) disable iff (rst)
    set_occ |=> occupied[$past(wr_idx)])
    else $error("watched slot not marked occupied");

  a_unwatch_frees_slot: assert property (@(posedge clk) disable iff (rst)
    clr_occ |=> !occupied[$past(wr_idx)])
    else $error("unwatched slot still marked occupied");

endmodule

`default_nettype wire

[rtl/task_watchdog_health_policy.sv]
// Top level of the task watchdog with heap health policy.
`default_nettype none

// Keeps a table of WATCH_SLOTS watched tasks and answers each command transaction (tick, watch,
// unwatch, kick) with exactly one result transaction. Every command walks the slot table, which
// lives in a synchronous memory read one entry per cycle: the scan reads each slot in turn, the apply
// step writes back the table and registers the scan result, the done step hands the result to the
// output register, and the block then returns to idle, where cmd_stall drops. The done step waits
// while an earlier result is still held by rsp_stall. cmd_stall stays high during reset
// and while a command is being processed, and a result that waits on rsp_stall does not keep the
// next command from being accepted. Tick results carry the heap verdict, the most overdue task
// and the fatal strike count; once a restart has been requested, later ticks change nothing
// until reset. Configuration writes on cfg_write take effect at once and belong to idle periods
// only.

module task_watchdog_health_policy #(
  parameter int WATCH_SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_write,
  input  logic [twhp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twhp_pkg::CFG_DATA_W-1:0] cfg_data,

  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [twhp_pkg::CMD_W-1:0]      command,
  input  logic [twhp_pkg::TIME_W-1:0]     time_ms,
  input  logic [twhp_pkg::ID_W-1:0]       task_id,
  input  logic [twhp_pkg::TIME_W-1:0]     silence_limit_ms,
  input  logic [twhp_pkg::FIG_W-1:0]      internal_free_bytes,
  input  logic [twhp_pkg::FIG_W-1:0]      largest_free_block,
  input  logic [twhp_pkg::FIG_W-1:0]      total_free_bytes,
  input  logic                            fatal_condition,

  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [twhp_pkg::STATUS_W-1:0]   status,
  output logic [twhp_pkg::MEM_W-1:0]      memory_state,
  output logic                            reboot_on_alarm,
  output logic                            task_stalled,
  output logic [twhp_pkg::OUT_SLOT_W-1:0] stalled_slot,
  output logic [twhp_pkg::AGE_W-1:0]      stalled_age_ms,
  output logic [twhp_pkg::STRIKE_W-1:0]   strike_count,
  output logic                            restart_request
);
  import twhp_pkg::*;

  logic [STRIKE_W-1:0] strike_limit;
  logic [KIB_W-1:0]    internal_alarm_kib;
  logic [KIB_W-1:0]    block_alarm_kib;
  logic [KIB_W-1:0]    internal_warn_kib;
  logic [KIB_W-1:0]    total_warn_kib;

  slot_req_t        req;
  logic [FIG_W-1:0] int_free;
  logic [FIG_W-1:0] blk_free;
  logic [FIG_W-1:0] tot_free;
  logic             fatal;

  logic        accept;
  logic        eng_busy;
  logic        eng_done;
  logic        finish;
  logic        commit;
  slot_rsp_t   eng_rsp;
  strike_rsp_t strike_rsp;
  logic [MEM_W-1:0] grade;

  assign cmd_stall = eng_busy || rst;
  assign accept    = cmd_valid && !cmd_stall;
  assign finish    = eng_done && (!rsp_valid || !rsp_stall);
  assign commit    = finish && (req.command == CMD_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      strike_limit       <= STRIKE_W'(1);
      internal_alarm_kib <= '0;
      block_alarm_kib    <= '0;
      internal_warn_kib  <= '0;
      total_warn_kib     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STRIKE_LIMIT:   strike_limit       <= cfg_data[STRIKE_W-1:0];
        CFG_INTERNAL_ALARM: internal_alarm_kib <= cfg_data[KIB_W-1:0];
        CFG_BLOCK_ALARM:    block_alarm_kib    <= cfg_data[KIB_W-1:0];
        CFG_INTERNAL_WARN:  internal_warn_kib  <= cfg_data[KIB_W-1:0];
        CFG_TOTAL_WARN:     total_warn_kib     <= cfg_data[KIB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.command          <= command;
      req.time_ms          <= time_ms;
      req.task_id          <= task_id;
      req.silence_limit_ms <= silence_limit_ms;
      int_free             <= internal_free_bytes;
      blk_free             <= largest_free_block;
      tot_free             <= total_free_bytes;
      fatal                <= fatal_condition;
    end
  end

  twhp_slot_engine #(
    .WATCH_SLOTS(WATCH_SLOTS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .finish(finish),
    .req   (req),
    .busy  (eng_busy),
    .done  (eng_done),
    .rsp   (eng_rsp)
  );

  twhp_heap_grade u_grade (
    .internal_free_bytes(int_free),
    .largest_free_block (blk_free),
    .total_free_bytes   (tot_free),
    .internal_alarm_kib (internal_alarm_kib),
    .block_alarm_kib    (block_alarm_kib),
    .internal_warn_kib  (internal_warn_kib),
    .total_warn_kib     (total_warn_kib),
    .memory_state       (grade)
  );

  twhp_strike u_strike (
    .clk            (clk),
    .rst            (rst),
    .commit         (commit),
    .fatal_condition(fatal),
    .strike_limit   (strike_limit),
    .rsp            (strike_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status          <= eng_rsp.status;
      memory_state    <= MEM_NORMAL;
      reboot_on_alarm <= 1'b0;
      task_stalled    <= 1'b0;
      stalled_slot    <= '0;
      stalled_age_ms  <= '0;
      strike_count    <= '0;
      restart_request <= 1'b0;
      if (req.command == CMD_TICK) begin
        strike_count <= strike_rsp.count;
        if (!strike_rsp.halted) begin
          memory_state    <= grade;
          reboot_on_alarm <= (grade == MEM_ALARM);
          task_stalled    <= eng_rsp.task_stalled;
          stalled_slot    <= eng_rsp.stalled_slot;
          stalled_age_ms  <= eng_rsp.stalled_age_ms;
          restart_request <= strike_rsp.restart;
        end
      end
    end
  end

endmodule

`default_nettype wire
